### rtl/core/decimal_text_to_float_defines.svh
// Assertion macros shared by the parser RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef DECIMAL_TEXT_TO_FLOAT_DEFINES_SVH
`define DECIMAL_TEXT_TO_FLOAT_DEFINES_SVH

// Same-cycle implication, checked on clk, disabled in reset.
`define DTTF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, disabled in reset.
`define DTTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/dttf_pkg.sv
// Types and constants for the decimal text to float parser.
// No dependencies; used by every module of the block.
package dttf_pkg;

  localparam int DIGIT_MAX_W = 30;
  localparam int NORM_W      = 32;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_POINT = 8'h2e;

  // single precision scale constants: 0.01, 0.1, 10.0
  localparam logic [23:0] MANT_P01 = 24'ha3d70a;
  localparam logic [9:0]  EXP_P01  = 10'd120;
  localparam logic [23:0] MANT_P1  = 24'hcccccd;
  localparam logic [9:0]  EXP_P1   = 10'd123;
  localparam logic [23:0] MANT_TEN = 24'ha00000;
  localparam logic [9:0]  EXP_TEN  = 10'd130;

  localparam logic [9:0]  EXP_BIAS = 10'd127;
  localparam logic [9:0]  EXP_INF  = 10'd255;
  localparam logic [9:0]  EXP_NORM_TOP = 10'd158;

  typedef struct packed {
    logic                   found;
    logic                   negative;
    logic [DIGIT_MAX_W-1:0] digits;
    logic signed [7:0]      dec_exp;
    logic [7:0]             chars;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_NORM,
    BK_MUL,
    BK_RND
  } back_state_t;

endpackage

### rtl/core/dttf_front.sv
// Character parser: tracks sign, kept digits, decimal exponent and position.
// Depends on dttf_pkg; pushes one job word per terminator into the queue.
`include "decimal_text_to_float_defines.svh"
module dttf_front #(
  parameter int MAX_DIGITS = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic           first_char,
  input  logic [7:0]     char_code,
  output logic           push,
  output dttf_pkg::job_t job
);
  import dttf_pkg::*;

  localparam int DW = $clog2(10 ** MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 2);
  localparam logic [CW-1:0] CNT_SAT = CW'(MAX_DIGITS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_DIGITS);

  logic              neg_r, neg_nxt;
  logic [DW-1:0]     dv_r, dv_nxt;
  logic signed [7:0] ex_r, ex_nxt;
  logic [CW-1:0]     dc_r, dc_nxt;
  logic              pt_r, pt_nxt;
  logic [7:0]        pos_r, pos_nxt;
  logic              busy_r, busy_nxt;

  logic [7:0]    d;
  logic          is_digit;
  logic [DW+3:0] dv_x10;

  assign d        = char_code - CH_ZERO;
  assign is_digit = (d <= 8'd9);

  always_comb begin
    neg_nxt  = neg_r;
    dv_nxt   = dv_r;
    ex_nxt   = ex_r;
    dc_nxt   = dc_r;
    pt_nxt   = pt_r;
    pos_nxt  = pos_r;
    busy_nxt = busy_r;
    push     = 1'b0;
    dv_x10   = '0;
    if (accept && (first_char || busy_r)) begin
      if (first_char) begin
        neg_nxt  = 1'b0;
        dv_nxt   = '0;
        ex_nxt   = '0;
        dc_nxt   = '0;
        pt_nxt   = 1'b0;
        pos_nxt  = '0;
        busy_nxt = 1'b1;
      end
      if (first_char && (char_code == CH_MINUS || char_code == CH_PLUS)) begin
        neg_nxt = (char_code == CH_MINUS);
        pos_nxt = 8'd1;
      end else if (is_digit) begin
        if (dc_nxt < CNT_SAT) dc_nxt = dc_nxt + 1'b1;
        if (dc_nxt <= CNT_MAX) begin
          if (pt_nxt) ex_nxt = ex_nxt - 8'sd1;
          dv_x10 = ({4'b0, dv_nxt} << 3) + ({4'b0, dv_nxt} << 1) + (DW+4)'(d[3:0]);
          dv_nxt = dv_x10[DW-1:0];
        end else if (!pt_nxt && ex_nxt < 8'sd127) begin
          ex_nxt = ex_nxt + 8'sd1;
        end
        if (pos_nxt != 8'hff) pos_nxt = pos_nxt + 8'd1;
      end else if (char_code == CH_POINT && !pt_nxt) begin
        pt_nxt = 1'b1;
        if (pos_nxt != 8'hff) pos_nxt = pos_nxt + 8'd1;
      end else begin
        busy_nxt = 1'b0;
        push     = 1'b1;
      end
    end
  end

  always_comb begin
    job.found    = (dc_nxt != '0);
    job.negative = neg_nxt;
    job.digits   = DIGIT_MAX_W'(dv_nxt);
    job.dec_exp  = ex_nxt;
    job.chars    = (dc_nxt != '0) ? pos_nxt : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_r  <= 1'b0;
      dv_r   <= '0;
      ex_r   <= '0;
      dc_r   <= '0;
      pt_r   <= 1'b0;
      pos_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      neg_r  <= neg_nxt;
      dv_r   <= dv_nxt;
      ex_r   <= ex_nxt;
      dc_r   <= dc_nxt;
      pt_r   <= pt_nxt;
      pos_r  <= pos_nxt;
      busy_r <= busy_nxt;
    end
  end

  `DTTF_ASSERT_NOW(a_cnt_sat, 1'b1, dc_r <= CNT_SAT, "digit count past saturation")
  `DTTF_ASSERT_NEXT(a_push_idle, push, !busy_r, "parser busy after terminator")

endmodule

### rtl/core/dttf_queue.sv
// Two-entry job queue between the parser and the float builder.
// Depends on dttf_pkg for the job word type.
`include "decimal_text_to_float_defines.svh"
module dttf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dttf_pkg::job_t push_job,
  output logic           full,
  output logic           not_empty,
  input  logic           pop,
  output dttf_pkg::job_t head
);
  import dttf_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && not_empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push && !full} - {1'b0, pop && not_empty};
    end
  end

  `DTTF_ASSERT_NOW(a_no_overflow, push, !full, "job pushed into full queue")
  `DTTF_ASSERT_NOW(a_ptr_match, cnt_r == 2'd1, wp_r != rp_r, "queue pointers disagree")

endmodule

### rtl/core/dttf_back.sv
// Float builder: converts the kept digits to single precision and scales.
// Depends on dttf_pkg; one shared 24x24 multiplier, registered before rounding.
`include "decimal_text_to_float_defines.svh"
module dttf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  input  dttf_pkg::job_t job,
  output logic           job_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_found,
  output logic [31:0]    out_value_bits,
  output logic [7:0]     out_chars_used
);
  import dttf_pkg::*;

  back_state_t state_r, state_nxt;

  logic [NORM_W-1:0] n_r, n_nxt;
  logic [9:0]        exp_r, exp_nxt;
  logic [23:0]       mant_r, mant_nxt;
  logic signed [7:0] e_r, e_nxt;
  logic              neg_r, neg_nxt;
  logic [7:0]        chars_r, chars_nxt;
  logic [47:0]       prod_r, prod_nxt;
  logic [9:0]        pexp_r, pexp_nxt;

  logic              ov_r, ov_nxt;
  logic              of_r, of_nxt;
  logic [31:0]       ob_r, ob_nxt;
  logic [7:0]        oc_r, oc_nxt;

  logic        slot_free, finish;
  logic [23:0] mb;
  logic [9:0]  eb;
  logic [23:0] rm;
  logic        rg, rs;
  logic [9:0]  rx;
  logic [24:0] m25;
  logic [23:0] rmant;
  logic [9:0]  rexp;

  assign slot_free = !ov_r || !out_stall;
  assign finish    = (state_r == BK_MUL) && (e_r == 8'sd0 || exp_r >= EXP_INF);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (job_valid && slot_free && job.found && job.digits != '0) state_nxt = BK_NORM;
      end
      BK_NORM: if (n_r[NORM_W-1]) state_nxt = BK_MUL;
      BK_MUL:  begin
        if (finish) begin
          if (slot_free) state_nxt = BK_IDLE;
        end else begin
          state_nxt = BK_RND;
        end
      end
      BK_RND:  state_nxt = BK_MUL;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // rounding source: normalized integer or registered product
  always_comb begin
    if (state_r == BK_NORM) begin
      rm = n_r[NORM_W-1 -: 24];
      rg = n_r[NORM_W-25];
      rs = |n_r[NORM_W-26:0];
      rx = exp_r;
    end else if (prod_r[47]) begin
      rm = prod_r[47:24];
      rg = prod_r[23];
      rs = |prod_r[22:0];
      rx = pexp_r + 10'd1;
    end else begin
      rm = prod_r[46:23];
      rg = prod_r[22];
      rs = |prod_r[21:0];
      rx = pexp_r;
    end
    m25 = {1'b0, rm} + {24'd0, rg && (rs || rm[0])};
    if (m25[24]) begin
      rmant = m25[24:1];
      rexp  = rx + 10'd1;
    end else begin
      rmant = m25[23:0];
      rexp  = rx;
    end
    if (rexp >= EXP_INF) begin
      rexp  = EXP_INF;
      rmant = 24'd0;
    end
  end

  // scale step: 0.01 while e <= -2, 0.1 at -1, 10 while e > 0
  always_comb begin
    if (e_r <= -8'sd2) begin
      mb = MANT_P01;
      eb = EXP_P01;
    end else if (e_r == -8'sd1) begin
      mb = MANT_P1;
      eb = EXP_P1;
    end else begin
      mb = MANT_TEN;
      eb = EXP_TEN;
    end
  end

  // datapath and outputs
  always_comb begin
    n_nxt     = n_r;
    exp_nxt   = exp_r;
    mant_nxt  = mant_r;
    e_nxt     = e_r;
    neg_nxt   = neg_r;
    chars_nxt = chars_r;
    prod_nxt  = prod_r;
    pexp_nxt  = pexp_r;
    ov_nxt    = ov_r && out_stall;
    of_nxt    = of_r;
    ob_nxt    = ob_r;
    oc_nxt    = oc_r;
    job_pop   = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (job_valid && slot_free) begin
          job_pop   = 1'b1;
          neg_nxt   = job.negative;
          chars_nxt = job.chars;
          e_nxt     = job.dec_exp;
          n_nxt     = NORM_W'(job.digits);
          exp_nxt   = EXP_NORM_TOP;
          if (!job.found || job.digits == '0) begin
            ov_nxt = 1'b1;
            of_nxt = job.found;
            ob_nxt = {job.found && job.negative, 31'd0};
            oc_nxt = job.chars;
          end
        end
      end
      BK_NORM: begin
        if (n_r[NORM_W-1]) begin
          mant_nxt = rmant;
          exp_nxt  = rexp;
        end else begin
          n_nxt   = n_r << 1;
          exp_nxt = exp_r - 10'd1;
        end
      end
      BK_MUL: begin
        if (finish) begin
          if (slot_free) begin
            ov_nxt = 1'b1;
            of_nxt = 1'b1;
            ob_nxt = {neg_r, exp_r[7:0], mant_r[22:0]};
            oc_nxt = chars_r;
          end
        end else begin
          prod_nxt = mant_r * mb;
          pexp_nxt = exp_r + eb - EXP_BIAS;
          if (e_r <= -8'sd2)       e_nxt = e_r + 8'sd2;
          else if (e_r == -8'sd1)  e_nxt = 8'sd0;
          else                     e_nxt = e_r - 8'sd1;
        end
      end
      BK_RND: begin
        mant_nxt = rmant;
        exp_nxt  = rexp;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    exp_r   <= exp_nxt;
    mant_r  <= mant_nxt;
    e_r     <= e_nxt;
    neg_r   <= neg_nxt;
    chars_r <= chars_nxt;
    prod_r  <= prod_nxt;
    pexp_r  <= pexp_nxt;
    of_r    <= of_nxt;
    ob_r    <= ob_nxt;
    oc_r    <= oc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid      = ov_r;
  assign out_found      = of_r;
  assign out_value_bits = ob_r;
  assign out_chars_used = oc_r;

  `DTTF_ASSERT_NOW(a_norm_nonzero, state_r == BK_NORM, n_r != '0, "normalizing a zero integer")
  `DTTF_ASSERT_NOW(a_pop_idle, job_pop, state_r == BK_IDLE, "job taken while busy")

endmodule

### rtl/core/decimal_text_to_float.sv
// ASCII decimal number parser producing IEEE single precision values.
//
// Input channel: in_valid / in_stall carry one character word per
// accepted cycle, with in_first_char marking the first character of a
// number. Characters arriving with no number open are dropped. The first
// character that does not extend the number ends it and yields one result
// word on out_valid / out_stall: found flag, value bits, characters used.
//
// Every character that is not a terminator only updates the parser state.
// A terminator is queued (two jobs deep) and built by the float unit: a
// start state, up to 31 one-bit normalizing shifts (at least 5 with eight
// kept digits) ending in rounding, then a multiply and a round per scale
// step through one shared 24x24 multiplier, about ceil(-e/2) steps for a
// negative exponent and e steps for a positive one, then a write into the
// output register.
// Input stalls only while the job queue is full; a stalled result holds
// in the output register and the float unit waits behind it.
// Reset (synchronous, active low) closes any open number, empties the
// queue and drops a pending result.
module decimal_text_to_float #(
  parameter int MAX_DIGITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_first_char,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [31:0] out_value_bits,
  output logic [7:0]  out_chars_used
);
  import dttf_pkg::*;

  logic full, not_empty, push, pop;
  job_t push_job, head;

  assign in_stall = full;

  dttf_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_valid && !in_stall),
    .first_char (in_first_char),
    .char_code  (in_char_code),
    .push       (push),
    .job        (push_job)
  );

  dttf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (full),
    .not_empty (not_empty),
    .pop       (pop),
    .head      (head)
  );

  dttf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (not_empty),
    .job            (head),
    .job_pop        (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found),
    .out_value_bits (out_value_bits),
    .out_chars_used (out_chars_used)
  );

endmodule
